FILE: hw/rtl/prm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse interval RPM meter package
// Shared constants, register indexes, controller states and the command and
// status words that join the controller to the datapath.
// ----------------------------------------------------------------------------
package prm_pkg;

	// Default timestamp width in bits.
	localparam int TIME_WIDTH_DEFAULT = 32;

	// Register field widths.
	localparam int DEBOUNCE_WIDTH = 20;
	localparam int SCALE_WIDTH    = 32;
	localparam int RATE_WIDTH     = 16;
	localparam int PULSE_WIDTH    = 32;

	// Register reset values.
	localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 20'd10000;
	localparam logic [SCALE_WIDTH-1:0]    SCALE_RESET    = 32'd60000000;
	localparam logic [RATE_WIDTH-1:0]     RATE_MAX       = 16'hFFFF;

	// One quotient bit per divider step, one step per dividend bit.
	localparam int DIV_STEPS  = SCALE_WIDTH;
	localparam int STEP_WIDTH = $clog2(DIV_STEPS);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_DEBOUNCE = 1'b0,
		REG_SCALE    = 1'b1
	} reg_index_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic in_ready;
		logic div_step;
		logic load_out;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_valid;
		logic emit;
		logic div_last;
		logic out_full;
		logic out_ready;
	} status_t;

endpackage

FILE: hw/rtl/prm_if.sv
// ----------------------------------------------------------------------------
// Pulse interval RPM meter stream interfaces
// Valid/ready channels for the pulse timestamp word and the rate word.
// ----------------------------------------------------------------------------
interface prm_pulse_if;
	logic                             valid;
	logic                             ready;
	logic [prm_pkg::PULSE_WIDTH-1:0]  pulse_time;

	modport source (output valid, output pulse_time, input ready);
	modport sink   (input valid, input pulse_time, output ready);
endinterface

interface prm_rate_if;
	logic                             valid;
	logic                             ready;
	logic [prm_pkg::RATE_WIDTH-1:0]   rotation_rate;

	modport source (output valid, output rotation_rate, input ready);
	modport sink   (input valid, input rotation_rate, output ready);
endinterface

FILE: hw/rtl/prm_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse interval RPM meter controller
// Sequences pulse acceptance, the restoring divide and the hand-off of the
// quotient into the output register.
// ----------------------------------------------------------------------------
module prm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  prm_pkg::status_t  status,
	output prm_pkg::cmd_t     cmd
);

	prm_pkg::state_t state_q;
	prm_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.in_ready = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			prm_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (status.in_valid && status.emit) begin
					state_d = prm_pkg::ST_DIVIDE;
				end
			end
			prm_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = prm_pkg::ST_DELIVER;
				end
			end
			prm_pkg::ST_DELIVER: begin
				// Wait until the output register is empty or being drained.
				if (!status.out_full || status.out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = prm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/prm_datapath.sv
// ----------------------------------------------------------------------------
// Pulse interval RPM meter datapath
// Configuration registers, debounce and interval accumulation, a one-bit-per-
// cycle restoring divider and the output register.
// ----------------------------------------------------------------------------
module prm_datapath #(
	parameter int TIME_WIDTH = prm_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  prm_pkg::reg_index_t               cfg_index,
	input  logic [prm_pkg::SCALE_WIDTH-1:0]   cfg_data,
	prm_pulse_if.sink                         pulse,
	prm_rate_if.source                        rate,
	input  prm_pkg::cmd_t                     cmd,
	output prm_pkg::status_t                  status
);

	localparam int DW = prm_pkg::DEBOUNCE_WIDTH;
	localparam int SW = prm_pkg::SCALE_WIDTH;
	localparam int RW = prm_pkg::RATE_WIDTH;

	// Configuration registers.
	logic [DW-1:0] debounce_q;
	logic [SW-1:0] scale_q;

	// Measurement state.
	logic [1:0]            count_q;
	logic [TIME_WIDTH-1:0] last_q;
	logic [TIME_WIDTH-1:0] sum_q;

	// Divider registers; the dividend register fills with quotient bits.
	logic [SW-1:0]                  dvd_q;
	logic [TIME_WIDTH-1:0]          div_q;
	logic [TIME_WIDTH-1:0]          rem_q;
	logic [prm_pkg::STEP_WIDTH-1:0] step_q;

	// Output register.
	logic [RW-1:0] out_q;
	logic          out_valid_q;

	logic [TIME_WIDTH+prm_pkg::PULSE_WIDTH-1:0] t_ext;
	logic [TIME_WIDTH-1:0]                      t_now;
	logic [TIME_WIDTH-1:0]                      diff;
	logic [TIME_WIDTH-1:0]                      sum_next;
	logic [TIME_WIDTH+DW-1:0]                   diff_ext;
	logic [TIME_WIDTH+DW-1:0]                   deb_ext;
	logic                                       pass;
	logic                                       accept;
	logic [TIME_WIDTH:0]                        shifted;
	logic [TIME_WIDTH:0]                        trial;
	logic                                       qbit;

	// Timestamp taken to the configured width, wrap-around difference.
	assign t_ext    = {{TIME_WIDTH{1'b0}}, pulse.pulse_time};
	assign t_now    = t_ext[TIME_WIDTH-1:0];
	assign diff     = t_now - last_q;
	assign sum_next = sum_q + diff;

	// Debounce: the first pulse after reset always counts.
	assign diff_ext = {{DW{1'b0}}, diff};
	assign deb_ext  = {{TIME_WIDTH{1'b0}}, debounce_q};
	assign pass     = (count_q == 2'd0) || (diff_ext > deb_ext);
	assign accept   = pulse.valid && cmd.in_ready;

	// One restoring step: shift in the next dividend bit, try the subtract.
	assign shifted = {rem_q, dvd_q[SW-1]};
	assign trial   = shifted - {1'b0, div_q};
	assign qbit    = !trial[TIME_WIDTH];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= prm_pkg::DEBOUNCE_RESET;
			scale_q    <= prm_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prm_pkg::REG_DEBOUNCE: debounce_q <= cfg_data[DW-1:0];
				prm_pkg::REG_SCALE:    scale_q    <= cfg_data;
				default:               debounce_q <= debounce_q;
			endcase
		end
	end

	// Measurement state update on an accepted, debounced pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			last_q  <= '0;
			sum_q   <= '0;
		end else if (accept && pass) begin
			last_q <= t_now;
			priority if (count_q == 2'd0) begin
				sum_q   <= '0;
				count_q <= 2'd1;
			end else if (count_q == 2'd2) begin
				sum_q   <= '0;
				count_q <= 2'd1;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 2'd1;
			end
		end
	end

	// Divider: loaded when a rotation closes, then one bit per step.
	always_ff @(posedge clk) begin
		if (accept && pass && (count_q == 2'd2)) begin
			dvd_q  <= scale_q;
			div_q  <= sum_next;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[SW-2:0], qbit};
			rem_q  <= qbit ? trial[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
			step_q <= step_q + 1'b1;
		end
	end

	// Output register with saturation; a zero divisor yields all ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rate.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= (|dvd_q[SW-1:RW]) ? prm_pkg::RATE_MAX : dvd_q[RW-1:0];
		end
	end

	assign pulse.ready        = cmd.in_ready;
	assign rate.valid         = out_valid_q;
	assign rate.rotation_rate = out_q;

	// Status back to the controller.
	assign status.in_valid  = pulse.valid;
	assign status.emit      = pass && (count_q == 2'd2);
	assign status.div_last  = (step_q == prm_pkg::STEP_WIDTH'(prm_pkg::DIV_STEPS - 1));
	assign status.out_full  = out_valid_q;
	assign status.out_ready = rate.ready;

endmodule

FILE: hw/rtl/pulse_interval_rpm_meter_unit.sv
// A closing pulse is followed by the divider steps and then the output load,
// which makes the rate word valid. Other pulses do not hold the input; a
// closing pulse holds it through the divide and the load, and longer while a
// rate word waits, with one quotient bit per divider step.
// Reset: arst_n clears the measurement, the output valid and the controller,
// and returns both registers to their defaults (10000 us, 60000000).
// ----------------------------------------------------------------------------
// Pulse interval RPM meter top level
// Debounced two-pulse-per-turn tachometer that emits scale / interval.
// ----------------------------------------------------------------------------
module pulse_interval_rpm_meter_unit #(
	parameter int TIME_WIDTH = prm_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  prm_pkg::reg_index_t               cfg_index,
	input  logic [prm_pkg::SCALE_WIDTH-1:0]   cfg_data,
	prm_pulse_if.sink                         pulse,
	prm_rate_if.source                        rate
);

	prm_pkg::cmd_t    cmd;
	prm_pkg::status_t status;

	// Sequencer.
	prm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Datapath.
	prm_datapath #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pulse     (pulse),
		.rate      (rate),
		.cmd       (cmd),
		.status    (status)
	);

`ifndef ASSERT_OFF
	// No pulse is taken while the divider is working.
	a_no_accept_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !pulse.ready)
		else $error("pulse accepted during divide");

	// A new result only follows an output load.
	a_valid_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rate.valid) |-> $past(cmd.load_out))
		else $error("result appeared without a load");

	// A load never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rate.valid || rate.ready))
		else $error("output overwritten before it was taken");

	// The divider steps are followed by the output load stage.
	a_divide_then_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && status.div_last) |=> !cmd.div_step && !pulse.ready)
		else $error("divide did not hand off to delivery");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Pulse interval RPM meter testbench
// Drives pulse timestamp words into the meter and checks every rate word against
// a cycle-free tachometer predictor kept alongside the block or, for some rows,
// a word from the short stimulus table, which covers debounce edges, timestamp
// wrap, zero and saturated rates and the register extremes. Random phases follow
// with idle and stall patterns on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_PULSES   = 64;
	localparam int PHASE_COUNT    = 5;
	localparam int HOLD_CYCLES    = 400;

	typedef enum logic {
		ROW_PULSE,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		prm_pkg::reg_index_t  index;
		logic [31:0]          value;
		logic                 has_rate;
		logic [15:0]          rate_word;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	prm_pkg::reg_index_t             cfg_index;
	logic [prm_pkg::SCALE_WIDTH-1:0] cfg_data;

	prm_pulse_if pulse_ch();
	prm_rate_if  rate_ch();

	pulse_interval_rpm_meter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pulse     (pulse_ch),
		.rate      (rate_ch)
	);

	// Tachometer state and register copies.
	logic [prm_pkg::DEBOUNCE_WIDTH-1:0] debounce_us;
	logic [prm_pkg::SCALE_WIDTH-1:0]    rate_numer;
	logic [1:0]                         edges_held;
	logic [31:0]                        last_edge_us;
	logic [31:0]                        period_sum;

	logic [prm_pkg::RATE_WIDTH-1:0] rpm_expected[$];
	stim_row_t                      stim_plan[$];
	int                             mismatches;
	int                             cycle_count;
	int                             tx_idle_pct;
	int                             rx_stall_pct;
	int                             rate_hold_cycles;

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Advance the tachometer by one pulse. Returns 1 when a rate word is due.
	function automatic logic tach_pulse(input logic [31:0] stamp, output logic taken,
			output logic [prm_pkg::RATE_WIDTH-1:0] rpm);
		logic [31:0] gap;
		logic [31:0] quot;
		logic        emits;
		gap   = stamp - last_edge_us;
		taken = 1'b0;
		rpm   = '0;
		emits = 1'b0;
		if (edges_held == 2'd0 || gap > {12'd0, debounce_us}) begin
			taken = 1'b1;
			if (edges_held == 2'd0)
				period_sum = '0;
			else
				period_sum = period_sum + gap;
			if (edges_held == 2'd2) begin
				if (period_sum == 32'd0) begin
					rpm = prm_pkg::RATE_MAX;
				end else begin
					quot = rate_numer / period_sum;
					rpm  = (quot > 32'(prm_pkg::RATE_MAX)) ? prm_pkg::RATE_MAX :
						quot[prm_pkg::RATE_WIDTH-1:0];
				end
				emits      = 1'b1;
				edges_held = 2'd0;
				period_sum = '0;
			end
			edges_held   = edges_held + 2'd1;
			last_edge_us = stamp;
		end
		return emits;
	endfunction

	// Offer one pulse word and wait for it to be taken.
	task automatic send_pulse(input logic [31:0] stamp, input logic has_rate,
			input logic [prm_pkg::RATE_WIDTH-1:0] rate_word, output logic taken);
		logic [prm_pkg::RATE_WIDTH-1:0] rpm;
		while ($urandom_range(99) < tx_idle_pct) begin
			pulse_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pulse_ch.valid      <= 1'b1;
		pulse_ch.pulse_time <= stamp;
		@(posedge clk);
		while (!pulse_ch.ready)
			@(posedge clk);
		if (tach_pulse(stamp, taken, rpm))
			rpm_expected.push_back(has_rate ? rate_word : rpm);
	endtask

	// Wait until every expected rate word is out, then let the block settle.
	task automatic drain_rates(input int settle);
		pulse_ch.valid <= 1'b0;
		while (rpm_expected.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Register write while the block is idle.
	task automatic write_reg(input prm_pkg::reg_index_t index, input logic [31:0] value);
		drain_rates(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (index == prm_pkg::REG_DEBOUNCE)
			debounce_us = value[prm_pkg::DEBOUNCE_WIDTH-1:0];
		else
			rate_numer = value;
	endtask

	// Rate word receiver: random stalls, or a long hold when one is requested.
	initial begin
		rate_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rate_hold_cycles > 0) begin
				rate_ch.ready <= 1'b0;
				rate_hold_cycles--;
			end else begin
				rate_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Rate word checker.
	always @(posedge clk) begin
		if (arst_n && rate_ch.valid && rate_ch.ready) begin
			if (rpm_expected.size() == 0) begin
				$error("rotation_rate: expected none, actual %0d", rate_ch.rotation_rate);
				mismatches++;
			end else begin
				if (rate_ch.rotation_rate !== rpm_expected[0]) begin
					$error("rotation_rate: expected %0d, actual %0d", rpm_expected[0],
						rate_ch.rotation_rate);
					mismatches++;
				end
				void'(rpm_expected.pop_front());
			end
		end
	end

	// Directed table: debounce edges, wrap, zero sum, saturation, extremes.
	initial begin
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd0, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd5000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd10000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd15000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd30000, 1'b1, 16'd2000});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'h8000_7530, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd30000, 1'b1,
			prm_pkg::RATE_MAX});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'h0000_3000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_WRITE, prm_pkg::REG_DEBOUNCE, 32'd0, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'h0000_3001, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'h0000_3001, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'h0000_3002, 1'b1,
			prm_pkg::RATE_MAX});
		stim_plan.push_back('{ROW_WRITE, prm_pkg::REG_SCALE, 32'd65535000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd12890, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd13290, 1'b1,
			prm_pkg::RATE_MAX});
		stim_plan.push_back('{ROW_WRITE, prm_pkg::REG_SCALE, 32'd1, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'hFFFF_FFFE, 1'b1, 16'd0});
		stim_plan.push_back('{ROW_WRITE, prm_pkg::REG_SCALE, 32'hFFFF_FFFF, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_WRITE, prm_pkg::REG_DEBOUNCE, 32'd1000000, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd999998, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd999999, 1'b0, 16'd0});
		stim_plan.push_back('{ROW_PULSE, prm_pkg::REG_DEBOUNCE, 32'd2999999, 1'b0, 16'd0});
	end

	// Main sequence.
	initial begin
		logic [31:0] stamp;
		logic [31:0] span;
		logic        taken;
		int          sent;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = prm_pkg::REG_DEBOUNCE;
		cfg_data            = '0;
		pulse_ch.valid      = 1'b0;
		pulse_ch.pulse_time = '0;
		mismatches          = 0;
		tx_idle_pct         = 0;
		rx_stall_pct        = 0;
		rate_hold_cycles    = 0;
		debounce_us         = prm_pkg::DEBOUNCE_RESET;
		rate_numer          = prm_pkg::SCALE_RESET;
		edges_held          = '0;
		last_edge_us        = '0;
		period_sum          = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, starting from the reset register values.
		foreach (stim_plan[i]) begin
			if (stim_plan[i].kind == ROW_WRITE)
				write_reg(stim_plan[i].index, stim_plan[i].value);
			else
				send_pulse(stim_plan[i].value, stim_plan[i].has_rate,
					stim_plan[i].rate_word, taken);
		end
		stamp = 32'd2999999;

		// Random phases, each with its own register setting and idle pattern.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					write_reg(prm_pkg::REG_DEBOUNCE, 32'd0);
					write_reg(prm_pkg::REG_SCALE, 32'hFFFF_FFFF);
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					write_reg(prm_pkg::REG_DEBOUNCE, 32'd1000000);
					write_reg(prm_pkg::REG_SCALE, $urandom);
					tx_idle_pct  = 59;
					rx_stall_pct = 0;
				end
				2: begin
					write_reg(prm_pkg::REG_DEBOUNCE, $urandom_range(0, 20000));
					write_reg(prm_pkg::REG_SCALE, $urandom_range(1, 32'hFFFF_FFFF));
					tx_idle_pct  = 0;
					rx_stall_pct = 59;
				end
				3: begin
					write_reg(prm_pkg::REG_DEBOUNCE, 32'(prm_pkg::DEBOUNCE_RESET));
					write_reg(prm_pkg::REG_SCALE, prm_pkg::SCALE_RESET);
					tx_idle_pct  = 21;
					rx_stall_pct = 21;
				end
				default: begin
					write_reg(prm_pkg::REG_DEBOUNCE, $urandom_range(0, 1000000));
					write_reg(prm_pkg::REG_SCALE, $urandom_range(1, 32'hFFFF_FFFF));
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					// Long receiver hold so the block fills and stalls its input.
					rate_hold_cycles = HOLD_CYCLES;
				end
			endcase

			sent = 0;
			while (sent < PHASE_PULSES) begin
				// Mostly well-spaced pulses, some bounce, some arbitrary stamps.
				case ($urandom_range(3))
					0: span = $urandom_range(0, 63);
					1: span = $urandom_range(0, 65535);
					2: span = $urandom_range(0, 32'h00FF_FFFF);
					default: span = $urandom;
				endcase
				case ($urandom_range(19))
					0, 1, 2: stamp = $urandom;
					3, 4, 5: stamp = stamp + $urandom_range(0, 32'(debounce_us));
					default: stamp = stamp + 32'(debounce_us) + 32'd1 + span;
				endcase
				send_pulse(stamp, 1'b0, '0, taken);
				if (taken)
					sent++;
				// Mid-way through the pressure phase, the sender pauses until every rate word so far is out.
				if (ph == PHASE_COUNT - 1 && taken && sent == PHASE_PULSES / 2)
					drain_rates(1);
			end
		end

		drain_rates(SETTLE_CYCLES);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/prm_pkg.sv
hw/rtl/prm_if.sv
hw/rtl/prm_ctrl.sv
hw/rtl/prm_datapath.sv
hw/rtl/pulse_interval_rpm_meter_unit.sv
tb/sv/testbench.sv
